### hw/rtl/blmf_pkg.sv
`timescale 1ns / 1ps

package blmf_pkg;

	localparam int PIXEL_W = 8;
	localparam int LINE_WIDTH_W = 11;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_GRAY_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH = 2'd2;

	localparam logic [PIXEL_W-1:0] GRAY_THRESHOLD_RESET = 8'd125;
	localparam logic [PIXEL_W-1:0] COLOR_THRESHOLD_RESET = 8'd115;
	localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd640;

	localparam int GRAY_SUM_W = 22;
	localparam int GRAY_SHIFT = 14;
	localparam logic [GRAY_SHIFT-1:0] GRAY_COEF_B = 14'd1868;
	localparam logic [GRAY_SHIFT-1:0] GRAY_COEF_G = 14'd9617;
	localparam logic [GRAY_SHIFT-1:0] GRAY_COEF_R = 14'd4899;
	localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = 22'd8192;

	typedef struct packed {
		logic [PIXEL_W-1:0] blue;
		logic [PIXEL_W-1:0] green;
		logic [PIXEL_W-1:0] red;
		logic start_of_frame;
		logic pad;
	} pixel_t;

	typedef struct packed {
		logic mask;
		logic end_of_line;
		logic last_of_run;
	} result_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] gray_threshold;
		logic [PIXEL_W-1:0] color_threshold;
		logic [LINE_WIDTH_W-1:0] line_width;
	} cfg_t;

	typedef struct packed {
		logic at_end;
		logic first_row;
		logic color_bit;
		logic bright;
	} item_flags_t;

endpackage

### hw/rtl/blmf_front.sv
`timescale 1ns / 1ps

module blmf_front #(
	parameter int MAX_WIDTH = 1024,
	localparam int XW = $clog2(MAX_WIDTH)
) (
	input logic clk,
	input logic arst_n,
	input blmf_pkg::cfg_t cfg,
	input logic hold,
	input logic pixel_valid,
	output logic pixel_stall,
	input blmf_pkg::pixel_t pixel,
	output logic item_valid,
	input logic item_full,
	output blmf_pkg::item_flags_t item_flags,
	output logic [XW-1:0] item_x
);
	import blmf_pkg::*;

	localparam int WW = (XW + 1 > LINE_WIDTH_W) ? XW + 1 : LINE_WIDTH_W;

	logic [XW-1:0] col_q;
	logic first_q;

	logic v_s1;
	logic [PIXEL_W-1:0] b_s1, g_s1, r_s1;
	logic pad_s1, end_s1, first_s1;
	logic [XW-1:0] x_s1;

	logic v_s2;
	logic [GRAY_SUM_W-1:0] pb_s2, pg_s2, pr_s2;
	logic cbit_s2, pad_s2, end_s2, first_s2;
	logic [XW-1:0] x_s2;

	logic [WW-1:0] lw_ext, w_eff, w_last;
	logic [XW-1:0] cc, x_now;
	logic at_end_now, first_now;
	logic adv1, adv2, acc;
	logic [PIXEL_W:0] diff;
	logic cbit;
	logic [GRAY_SUM_W-1:0] gray_sum;

	always_comb begin
		lw_ext = WW'(cfg.line_width);
		if (lw_ext < WW'(2)) begin
			w_eff = WW'(2);
		end else if (lw_ext > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = lw_ext;
		end
		w_last = w_eff - WW'(1);
		cc = pixel.start_of_frame ? '0 : col_q;
		first_now = pixel.start_of_frame | first_q;
		if (WW'(cc) >= w_last) begin
			x_now = w_last[XW-1:0];
			at_end_now = 1'b1;
		end else begin
			x_now = cc;
			at_end_now = 1'b0;
		end
	end

	assign adv2 = !v_s2 || !item_full;
	assign adv1 = !v_s1 || adv2;
	assign pixel_stall = hold || !adv1;
	assign acc = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			first_q <= 1'b1;
		end else if (acc) begin
			col_q <= at_end_now ? '0 : x_now + XW'(1);
			first_q <= at_end_now ? 1'b0 : first_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= acc;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && acc) begin
			b_s1 <= pixel.blue;
			g_s1 <= pixel.green;
			r_s1 <= pixel.red;
			pad_s1 <= pixel.pad;
			x_s1 <= x_now;
			end_s1 <= at_end_now;
			first_s1 <= first_now;
		end
	end

	assign diff = {1'b0, b_s1} - {1'b0, r_s1};
	assign cbit = !pad_s1 && !diff[PIXEL_W] && (diff[PIXEL_W-1:0] > cfg.color_threshold);

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			pb_s2 <= GRAY_SUM_W'(GRAY_COEF_B) * GRAY_SUM_W'(b_s1);
			pg_s2 <= GRAY_SUM_W'(GRAY_COEF_G) * GRAY_SUM_W'(g_s1);
			pr_s2 <= GRAY_SUM_W'(GRAY_COEF_R) * GRAY_SUM_W'(r_s1);
			cbit_s2 <= cbit;
			pad_s2 <= pad_s1;
			x_s2 <= x_s1;
			end_s2 <= end_s1;
			first_s2 <= first_s1;
		end
	end

	assign gray_sum = pb_s2 + pg_s2 + pr_s2 + GRAY_ROUND;

	always_comb begin
		item_flags.at_end = end_s2;
		item_flags.first_row = first_s2;
		item_flags.color_bit = cbit_s2;
		item_flags.bright = !pad_s2 &&
			(gray_sum[GRAY_SUM_W-1:GRAY_SHIFT] > cfg.gray_threshold);
	end

	assign item_valid = v_s2;
	assign item_x = x_s2;

endmodule

### hw/rtl/blmf_fifo.sv
`timescale 1ns / 1ps

module blmf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic full,
	input logic [WIDTH-1:0] push_data,
	output logic pop_valid,
	input logic pop,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic push_en, pop_en;

	assign full = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign push_en = push_valid && !full;
	assign pop_en = pop && pop_valid;
	assign pop_data = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push_en) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop_en) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			count_q <= count_q + CW'(push_en) - CW'(pop_en);
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			slots_q[wr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/blmf_back.sv
`timescale 1ns / 1ps

module blmf_back #(
	parameter int MAX_WIDTH = 1024,
	localparam int XW = $clog2(MAX_WIDTH)
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_pop,
	input blmf_pkg::item_flags_t item_flags,
	input logic [XW-1:0] item_x,
	output logic clear_busy,
	output logic result_valid,
	input logic result_stall,
	output blmf_pkg::result_t result
);
	import blmf_pkg::*;

	// Row store bits: colour bit of the previous row, product bits of the two previous rows.
	localparam int ROW_COLOR = 2;
	localparam int ROW_NEAR = 1;
	localparam int ROW_FAR = 0;

	logic [2:0] row_mem [MAX_WIDTH];

	logic clr_busy_q;
	logic [XW-1:0] clr_addr_q;

	logic v_s3;
	item_flags_t flags_s3;
	logic [XW-1:0] x_s3;
	logic [2:0] rd_s3;

	logic left_q;
	logic [8:0] window_q;

	logic [1:0] ocnt_q;
	result_t slot0_q, slot1_q;

	logic up_h, near_b, far_b, hbit, prod;
	logic [2:0] newcol;
	logic [8:0] win_new;
	logic emit, two, room, fire, ld3, opop;
	logic [1:0] k, npush;
	result_t r0, r1, remhead;

	always_comb begin
		up_h = !flags_s3.first_row && rd_s3[ROW_COLOR];
		near_b = !flags_s3.first_row && rd_s3[ROW_NEAR];
		far_b = !flags_s3.first_row && rd_s3[ROW_FAR];
		hbit = flags_s3.color_bit | ((x_s3 != '0) & left_q);
		prod = (hbit | up_h) & flags_s3.bright;
		newcol = {far_b, near_b, prod};
		win_new = (x_s3 == '0) ? {6'b0, newcol} : {window_q[5:0], newcol};
		emit = !flags_s3.first_row && (x_s3 != '0);
		two = emit && flags_s3.at_end;

		opop = (ocnt_q != 2'd0) && !result_stall;
		k = ocnt_q - {1'b0, opop};
		if (two) begin
			room = (k == 2'd0);
		end else if (emit) begin
			room = (k <= 2'd1);
		end else begin
			room = 1'b1;
		end
		fire = v_s3 && room;
		ld3 = !v_s3 || fire;
		item_pop = item_valid && ld3 && !clr_busy_q;

		if (!fire) begin
			npush = 2'd0;
		end else if (two) begin
			npush = 2'd2;
		end else if (emit) begin
			npush = 2'd1;
		end else begin
			npush = 2'd0;
		end

		r0.mask = (win_new != '0);
		r0.end_of_line = 1'b0;
		r0.last_of_run = !flags_s3.at_end;
		r1.mask = (win_new[5:0] != '0);
		r1.end_of_line = 1'b1;
		r1.last_of_run = 1'b1;
		remhead = opop ? slot1_q : slot0_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + XW'(1);
			if (clr_addr_q == XW'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			row_mem[clr_addr_q] <= 3'b000;
		end else if (fire) begin
			row_mem[x_s3] <= {hbit, prod, near_b};
		end
		if (item_pop) begin
			rd_s3 <= row_mem[item_x];
			flags_s3 <= item_flags;
			x_s3 <= item_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			left_q <= 1'b0;
			window_q <= '0;
			ocnt_q <= 2'd0;
		end else begin
			if (ld3) begin
				v_s3 <= item_pop;
			end
			if (fire) begin
				left_q <= flags_s3.color_bit;
				window_q <= win_new;
			end
			ocnt_q <= k + npush;
		end
	end

	always_ff @(posedge clk) begin
		slot0_q <= (k != 2'd0) ? remhead : r0;
		if (k == 2'd2) begin
			slot1_q <= slot1_q;
		end else if (k != 2'd0) begin
			slot1_q <= r0;
		end else begin
			slot1_q <= r1;
		end
	end

	assign clear_busy = clr_busy_q;
	assign result_valid = (ocnt_q != 2'd0);
	assign result = slot0_q;

endmodule

### hw/rtl/blue_light_mask_filter_core.sv
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while pixel_stall is low; a row of N pixels gives N results,
// except the first row of a frame, which gives none. A pixel passes stages s1, s2, the queue and s3.
// The row store has a read and a write port: read on issue, written when the item leaves s3.
// Reset: after arst_n all MAX_WIDTH row store entries are cleared, with pixel_stall high.
// Configuration writes are taken during that pass; registers reset to 125, 115 and 640.

module blue_light_mask_filter_core #(
	parameter int MAX_WIDTH = 1024,
	parameter int QUEUE_DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [blmf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [blmf_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic pixel_valid,
	output logic pixel_stall,
	input blmf_pkg::pixel_t pixel,
	output logic result_valid,
	input logic result_stall,
	output blmf_pkg::result_t result
);
	import blmf_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int FW = $bits(item_flags_t);

	cfg_t cfg_q;
	logic clear_busy;

	logic f_valid, q_full, q_valid, q_pop;
	item_flags_t f_flags, q_flags;
	logic [XW-1:0] f_x, q_x;
	logic [XW+FW-1:0] q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gray_threshold <= GRAY_THRESHOLD_RESET;
			cfg_q.color_threshold <= COLOR_THRESHOLD_RESET;
			cfg_q.line_width <= LINE_WIDTH_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_GRAY_THRESHOLD: begin
					cfg_q.gray_threshold <= cfg_data[PIXEL_W-1:0];
				end
				REG_COLOR_THRESHOLD: begin
					cfg_q.color_threshold <= cfg_data[PIXEL_W-1:0];
				end
				REG_LINE_WIDTH: begin
					cfg_q.line_width <= cfg_data[LINE_WIDTH_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	blmf_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.hold(clear_busy),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.item_valid(f_valid),
		.item_full(q_full),
		.item_flags(f_flags),
		.item_x(f_x)
	);

	blmf_fifo #(
		.WIDTH(XW + FW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(f_valid),
		.full(q_full),
		.push_data({f_x, f_flags}),
		.pop_valid(q_valid),
		.pop(q_pop),
		.pop_data(q_data)
	);

	assign q_x = q_data[XW+FW-1:FW];
	assign q_flags = q_data[FW-1:0];

	blmf_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(q_valid),
		.item_pop(q_pop),
		.item_flags(q_flags),
		.item_x(q_x),
		.clear_busy(clear_busy),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule
